>>> rtl/deq_pkg.sv
// Shared constants, types and helpers for the double-ended queue.
`timescale 1ns / 1ps

package deq_pkg;

    localparam int DEPTH       = 1024;
    localparam int WORD_WIDTH  = 32;
    localparam int PTR_W       = $clog2(DEPTH);
    localparam int CNT_W       = $clog2(DEPTH + 1);
    localparam int FUNC_W      = 3;
    localparam int OUT_W       = 32;
    localparam int STATUS_W    = 2;
    localparam int OCC_W       = 11;
    localparam int IN_FIELDS_W = FUNC_W + OUT_W;
    localparam int IN_TDATA_W  = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_FIELDS_W = STATUS_W + 3 * OUT_W + OCC_W;
    localparam int OUT_TDATA_W = ((OUT_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_PAD_W   = OUT_TDATA_W - OUT_FIELDS_W;

    typedef enum logic [FUNC_W-1:0] {
        FN_PUSH_FRONT = 3'd0,
        FN_PUSH_BACK  = 3'd1,
        FN_POP_FRONT  = 3'd2,
        FN_POP_BACK   = 3'd3,
        FN_CLEAR      = 3'd4,
        FN_QUERY      = 3'd5
    } t_func;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_FETCH,
        S_DONE
    } t_state;

    typedef struct packed {
        logic capture;
        logic exec;
        logic fetch;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic need_fetch;
        logic out_free;
    } t_sts;

    function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] idx);
        logic [PTR_W-1:0] res;
        if (idx == PTR_W'(DEPTH - 1)) begin
            res = '0;
        end else begin
            res = idx + PTR_W'(1);
        end
        return res;
    endfunction

    function automatic logic [PTR_W-1:0] ring_prev(input logic [PTR_W-1:0] idx);
        logic [PTR_W-1:0] res;
        if (idx == '0) begin
            res = PTR_W'(DEPTH - 1);
        end else begin
            res = idx - PTR_W'(1);
        end
        return res;
    endfunction

endpackage

>>> rtl/deq_ctrl.sv
// Request sequencer for the double-ended queue.
`timescale 1ns / 1ps

module deq_ctrl
    import deq_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_s_tvalid,
    output logic o_s_tready,
    output t_cmd o_cmd,
    input  t_sts i_sts
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) n_state = S_EXEC;
            end
            S_EXEC: begin
                n_state = i_sts.need_fetch ? S_FETCH : S_DONE;
            end
            S_FETCH: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                if (i_sts.out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_s_tready       = (r_state == S_IDLE);
        o_cmd.capture    = (r_state == S_IDLE) && i_s_tvalid;
        o_cmd.exec       = (r_state == S_EXEC);
        o_cmd.fetch      = (r_state == S_FETCH);
        o_cmd.load_out   = (r_state == S_DONE) && i_sts.out_free;
    end

endmodule

>>> rtl/deq_dp.sv
// Ring memory, pointers, end-word cache and output register of the queue.
`timescale 1ns / 1ps

module deq_dp
    import deq_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_cmd                   i_cmd,
    output t_sts                   o_sts,
    input  logic [IN_TDATA_W-1:0]  i_s_tdata,
    output logic                   o_m_tvalid,
    input  logic                   i_m_tready,
    output logic [OUT_TDATA_W-1:0] o_m_tdata
);

    logic [WORD_WIDTH-1:0] ring_mem [DEPTH];

    t_func                 r_func;
    logic [WORD_WIDTH-1:0] r_value;
    logic [PTR_W-1:0]      r_head, n_head;
    logic [PTR_W-1:0]      r_tail, n_tail;
    logic [CNT_W-1:0]      r_count, n_count;
    logic [WORD_WIDTH-1:0] r_front, n_front;
    logic [WORD_WIDTH-1:0] r_back, n_back;
    t_status               r_status, n_status;
    logic [OUT_W-1:0]      r_popped, n_popped;
    logic [WORD_WIDTH-1:0] r_rd_data;
    logic                  r_out_valid;
    logic [OUT_TDATA_W-1:0] r_out_data;

    logic                  mem_we;
    logic [PTR_W-1:0]      mem_wa;
    logic [PTR_W-1:0]      rd_addr;
    logic                  is_empty;
    logic                  is_full;
    logic [OUT_W-1:0]      front_out;
    logic [OUT_W-1:0]      back_out;

    assign is_empty = (r_count == '0);
    assign is_full  = (r_count == CNT_W'(DEPTH));
    assign rd_addr  = (r_func == FN_POP_FRONT) ? ring_next(r_head) : ring_prev(r_tail);

    // A pop that leaves words behind must fetch the new end word.
    assign o_sts.need_fetch = ((r_func == FN_POP_FRONT) || (r_func == FN_POP_BACK))
                              && (r_count > CNT_W'(1));
    assign o_sts.out_free   = !r_out_valid || i_m_tready;

    always_comb begin
        n_head   = r_head;
        n_tail   = r_tail;
        n_count  = r_count;
        n_front  = r_front;
        n_back   = r_back;
        n_status = r_status;
        n_popped = r_popped;
        mem_we   = 1'b0;
        mem_wa   = r_head;
        if (i_cmd.exec) begin
            n_status = ST_OK;
            n_popped = '1;
            unique case (r_func)
                FN_PUSH_FRONT, FN_PUSH_BACK: begin
                    if (is_full) begin
                        n_status = ST_FULL;
                    end else begin
                        mem_we  = 1'b1;
                        n_count = r_count + CNT_W'(1);
                        if (is_empty) begin
                            mem_wa  = r_head;
                            n_tail  = r_head;
                            n_front = r_value;
                            n_back  = r_value;
                        end else if (r_func == FN_PUSH_FRONT) begin
                            n_head  = ring_prev(r_head);
                            mem_wa  = ring_prev(r_head);
                            n_front = r_value;
                        end else begin
                            n_tail  = ring_next(r_tail);
                            mem_wa  = ring_next(r_tail);
                            n_back  = r_value;
                        end
                    end
                end
                FN_POP_FRONT: begin
                    if (is_empty) begin
                        n_status = ST_EMPTY;
                    end else begin
                        n_popped = OUT_W'(r_front);
                        n_count  = r_count - CNT_W'(1);
                        if (r_count != CNT_W'(1)) n_head = ring_next(r_head);
                    end
                end
                FN_POP_BACK: begin
                    if (is_empty) begin
                        n_status = ST_EMPTY;
                    end else begin
                        n_popped = OUT_W'(r_back);
                        n_count  = r_count - CNT_W'(1);
                        if (r_count != CNT_W'(1)) n_tail = ring_prev(r_tail);
                    end
                end
                FN_CLEAR: begin
                    n_count = '0;
                    n_head  = '0;
                    n_tail  = '0;
                end
                default: ;
            endcase
        end
        if (i_cmd.fetch) begin
            if (r_func == FN_POP_FRONT) begin
                n_front = r_rd_data;
            end else begin
                n_back = r_rd_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) ring_mem[mem_wa] <= r_value;
        r_rd_data <= ring_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_front  <= n_front;
        r_back   <= n_back;
        r_status <= n_status;
        r_popped <= n_popped;
        if (i_cmd.capture) begin
            r_func  <= t_func'(i_s_tdata[FUNC_W-1:0]);
            r_value <= WORD_WIDTH'(i_s_tdata[FUNC_W +: OUT_W]);
        end
    end

    assign front_out = is_empty ? '1 : OUT_W'(r_front);
    assign back_out  = is_empty ? '1 : OUT_W'(r_back);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_data <= {{OUT_PAD_W{1'b0}}, OCC_W'(r_count), back_out, front_out,
                           r_popped, r_status};
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

endmodule

>>> rtl/double_ended_queue.sv
// Top level of the double-ended queue: sequencer plus datapath.
`timescale 1ns / 1ps
//
// Channel   Dir  tdata fields (low bit up)
// s_axis    in   func[2:0], value[34:3], zero pad to 40 bits
// m_axis    out  status[1:0], popped[33:2], front_word[65:34],
//                back_word[97:66], occupancy[108:98], zero pad to 112 bits
//
// One request at a time: each request is accepted, executed and loaded into the
// output, with a fetch step before the load for a pop that leaves words behind,
// whose new end word comes from the registered read port of the ring memory.
// Reset clears pointers and count; the ring memory is not cleared.
// The next request is taken while a result waits; a stalled m_axis holds the
// sequencer only once a second result is ready.

module double_ended_queue
    import deq_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  i_s_axis_tdata,   // func, value
    output logic                   o_m_axis_tvalid,
    input  logic                   i_m_axis_tready,
    output logic [OUT_TDATA_W-1:0] o_m_axis_tdata    // status, popped, front, back, occupancy
);

    t_cmd cmd;
    t_sts sts;

    deq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_axis_tvalid),
        .o_s_tready (o_s_axis_tready),
        .o_cmd      (cmd),
        .i_sts      (sts)
    );

    deq_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .i_s_tdata  (i_s_axis_tdata),
        .o_m_tvalid (o_m_axis_tvalid),
        .i_m_tready (i_m_axis_tready),
        .o_m_tdata  (o_m_axis_tdata)
    );

`ifndef SYNTHESIS
    a_one_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready) |=> !o_s_axis_tready)
        else $error("second request accepted while one is in flight");

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.load_out |-> sts.out_free)
        else $error("result loaded over an unconsumed result");

    a_empty_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && (o_m_axis_tdata[1:0] == ST_EMPTY)) |->
        ((o_m_axis_tdata[108:98] == '0) && (o_m_axis_tdata[33:2] == '1)))
        else $error("empty error with words held or a popped word");

    a_empty_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && (o_m_axis_tdata[108:98] == '0)) |->
        ((o_m_axis_tdata[65:34] == '1) && (o_m_axis_tdata[97:66] == '1)))
        else $error("empty queue reports an end word");
`endif

endmodule

>>> tb/tb_double_ended_queue.sv
// Self-checking testbench for the double-ended queue: directed and random requests.
`timescale 1ns / 1ps

module tb_double_ended_queue;
    import deq_pkg::*;

    localparam logic [FUNC_W-1:0] FN_SPARE_6 = 3'd6;
    localparam logic [FUNC_W-1:0] FN_SPARE_7 = 3'd7;
    localparam logic [31:0]       NO_WORD    = 32'hFFFF_FFFF;
    localparam int                MAX_SHOWN  = 10;
    localparam int                EXP_SLOTS  = 64;

    // Lowest field last, matching the tdata packing
    typedef struct packed {
        logic [OCC_W-1:0]    occupancy;
        logic [31:0]         back_word;
        logic [31:0]         front_word;
        logic [31:0]         popped;
        logic [STATUS_W-1:0] status;
    } t_deq_result;

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   req_valid = 1'b0;
    logic                   req_ready;
    logic [IN_TDATA_W-1:0]  req_data  = '0;
    logic                   res_valid;
    logic                   res_ready = 1'b0;
    logic [OUT_TDATA_W-1:0] res_data;

    // Shadow copy of the queue state
    logic [31:0]      shadow_ring [DEPTH];
    logic [PTR_W-1:0] shadow_head;
    logic [PTR_W-1:0] shadow_tail;
    logic [CNT_W-1:0] shadow_count;

    // Expected results in request order
    t_deq_result      exp_store [EXP_SLOTS];
    int               exp_wr = 0;
    int               exp_rd = 0;
    t_deq_result      want;
    t_deq_result      seen;

    bit idle_on     = 1'b1;
    int stall_left  = 0;
    int n_requests  = 0;
    int n_results   = 0;
    int n_errors    = 0;
    int n_full_hits = 0;
    int n_empty_hits = 0;
    int peak_count  = 0;

    double_ended_queue dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (req_valid),
        .o_s_axis_tready (req_ready),
        .i_s_axis_tdata  (req_data),   // func, value, zero pad
        .o_m_axis_tvalid (res_valid),
        .i_m_axis_tready (res_ready),
        .o_m_axis_tdata  (res_data)    // status, popped, front, back, occupancy, zero pad
    );

    initial begin
        forever #4 clk = ~clk;
    end

    initial begin
        #5ms;
        $display("TEST FAILED");
        $finish;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (!idle_on || r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 9))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return 32'h0000_0000;
            3:       return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    // Result side: stall the consumer in random bursts
    always @(posedge clk) begin
        if (!idle_on) begin
            res_ready  <= 1'b1;
            stall_left <= 0;
        end else if (stall_left > 0) begin
            res_ready  <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (res_ready && $urandom_range(0, 99) < 30) begin
            res_ready  <= 1'b0;
            stall_left <= pick_gap();
        end else begin
            res_ready  <= 1'b1;
        end
    end

    task automatic reset_shadow();
        shadow_head  = '0;
        shadow_tail  = '0;
        shadow_count = '0;
    endtask

    // Apply one request to the shadow state and queue the result it causes
    task automatic predict_request(input logic [FUNC_W-1:0] fn, input logic [31:0] val);
        t_deq_result r;
        r.status = ST_OK;
        r.popped = NO_WORD;
        case (fn)
            FN_PUSH_FRONT, FN_PUSH_BACK: begin
                if (shadow_count >= CNT_W'(DEPTH)) begin
                    r.status = ST_FULL;
                    n_full_hits++;
                end else begin
                    if (shadow_count == '0) begin
                        shadow_tail = shadow_head;
                        shadow_ring[shadow_head] = val;
                    end else if (fn == FN_PUSH_FRONT) begin
                        shadow_head = (shadow_head == '0) ? PTR_W'(DEPTH - 1)
                                                          : shadow_head - 1'b1;
                        shadow_ring[shadow_head] = val;
                    end else begin
                        shadow_tail = (shadow_tail == PTR_W'(DEPTH - 1)) ? '0
                                                                         : shadow_tail + 1'b1;
                        shadow_ring[shadow_tail] = val;
                    end
                    shadow_count++;
                end
            end
            FN_POP_FRONT, FN_POP_BACK: begin
                if (shadow_count == '0) begin
                    r.status = ST_EMPTY;
                    n_empty_hits++;
                end else if (fn == FN_POP_FRONT) begin
                    r.popped = shadow_ring[shadow_head];
                    shadow_count--;
                    if (shadow_count != '0)
                        shadow_head = (shadow_head == PTR_W'(DEPTH - 1)) ? '0
                                                                         : shadow_head + 1'b1;
                end else begin
                    r.popped = shadow_ring[shadow_tail];
                    shadow_count--;
                    if (shadow_count != '0)
                        shadow_tail = (shadow_tail == '0) ? PTR_W'(DEPTH - 1)
                                                          : shadow_tail - 1'b1;
                end
            end
            FN_CLEAR: begin
                reset_shadow();
            end
            default: ;
        endcase
        if (shadow_count == '0) begin
            r.front_word = NO_WORD;
            r.back_word  = NO_WORD;
        end else begin
            r.front_word = shadow_ring[shadow_head];
            r.back_word  = shadow_ring[shadow_tail];
        end
        r.occupancy = OCC_W'(shadow_count);
        if (int'(shadow_count) > peak_count) peak_count = int'(shadow_count);
        exp_store[exp_wr % EXP_SLOTS] = r;
        exp_wr++;
    endtask

    // Send one request; valid stays high when the next one follows without a gap
    task automatic send_request(input logic [FUNC_W-1:0] fn, input logic [31:0] val);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req_data  <= {{(IN_TDATA_W - IN_FIELDS_W){1'b0}}, val, fn};
        @(posedge clk);
        while (!req_ready) @(posedge clk);
        predict_request(fn, val);
        n_requests++;
    endtask

    task automatic note_mismatch(input string field, input logic [31:0] exp_v,
                                 input logic [31:0] act_v);
        n_errors++;
        if (n_errors <= MAX_SHOWN)
            $display("[%0t] result %0d: %s expected %h, got %h",
                     $realtime, n_results, field, exp_v, act_v);
    endtask

    always @(posedge clk) begin
        if (rst_n && res_valid && res_ready) begin
            seen = res_data[OUT_FIELDS_W-1:0];
            if (exp_wr == exp_rd) begin
                note_mismatch("unexpected result, status", '0, 32'(seen.status));
            end else begin
                want = exp_store[exp_rd % EXP_SLOTS];
                exp_rd++;
                if (seen.status !== want.status)
                    note_mismatch("status", 32'(want.status), 32'(seen.status));
                if (seen.popped !== want.popped)
                    note_mismatch("popped", want.popped, seen.popped);
                if (seen.front_word !== want.front_word)
                    note_mismatch("front_word", want.front_word, seen.front_word);
                if (seen.back_word !== want.back_word)
                    note_mismatch("back_word", want.back_word, seen.back_word);
                if (seen.occupancy !== want.occupancy)
                    note_mismatch("occupancy", 32'(want.occupancy), 32'(seen.occupancy));
                if (res_data[OUT_TDATA_W-1:OUT_FIELDS_W] !== '0)
                    note_mismatch("pad", '0, 32'(res_data[OUT_TDATA_W-1:OUT_FIELDS_W]));
            end
            n_results++;
        end
    end

    // Every request but the pushes on an empty queue, spare codes included
    task automatic test_empty_queue();
        send_request(FN_QUERY, 32'h1234_5678);
        send_request(FN_POP_FRONT, 32'h0);
        send_request(FN_POP_BACK, 32'hFFFF_FFFF);
        send_request(FN_SPARE_6, 32'hFFFF_FFFF);
        send_request(FN_SPARE_7, 32'h0);
        send_request(FN_CLEAR, 32'hA5A5_A5A5);
    endtask

    // Extremes through both ends, last-word pops and clear with words held
    task automatic test_both_ends();
        send_request(FN_PUSH_FRONT, 32'h7FFF_FFFF);
        send_request(FN_PUSH_BACK, 32'h8000_0000);
        send_request(FN_PUSH_FRONT, 32'hFFFF_FFFF);
        send_request(FN_PUSH_BACK, 32'h0000_0000);
        send_request(FN_SPARE_6, 32'h5555_5555);
        send_request(FN_SPARE_7, 32'hAAAA_AAAA);
        send_request(FN_POP_FRONT, 32'h0);
        send_request(FN_POP_BACK, 32'h0);
        send_request(FN_POP_FRONT, 32'h0);
        send_request(FN_POP_BACK, 32'h0);
        send_request(FN_POP_FRONT, 32'h0);
        // indices stay put after the last pop; push lands there
        send_request(FN_PUSH_BACK, 32'h0000_0001);
        send_request(FN_PUSH_BACK, 32'h8000_0001);
        send_request(FN_POP_FRONT, 32'h0);
        send_request(FN_POP_FRONT, 32'h0);
        send_request(FN_PUSH_FRONT, 32'hDEAD_BEEF);
        send_request(FN_CLEAR, 32'h0);
        send_request(FN_QUERY, 32'h0);
    endtask

    // Fill to capacity with wrapping indices, hit full at both ends, refill
    task automatic test_full_queue();
        send_request(FN_CLEAR, 32'h0);
        repeat (DEPTH)
            send_request($urandom_range(0, 1) ? FN_PUSH_BACK : FN_PUSH_FRONT, pick_word());
        send_request(FN_PUSH_FRONT, 32'h1111_1111);
        send_request(FN_PUSH_BACK, 32'h2222_2222);
        send_request(FN_QUERY, 32'h0);
        repeat (20)
            send_request($urandom_range(0, 1) ? FN_POP_BACK : FN_POP_FRONT, 32'h0);
        repeat (21)
            send_request($urandom_range(0, 1) ? FN_PUSH_BACK : FN_PUSH_FRONT, pick_word());
        send_request(FN_CLEAR, 32'h0);
        send_request(FN_POP_BACK, 32'h0);
    endtask

    // Random mix in blocks that grow, shrink or hover, idling on and off
    task automatic test_random_mix();
        int push_pct;
        int r;
        for (int blk = 0; blk < 3; blk++) begin
            case ($urandom_range(0, 2))
                0:       push_pct = 80;
                1:       push_pct = 25;
                default: push_pct = 50;
            endcase
            idle_on = ($urandom_range(0, 3) != 0);
            repeat (60) begin
                r = $urandom_range(0, 99);
                if (r < 1)
                    send_request(FN_CLEAR, pick_word());
                else if (r < 6)
                    send_request(FN_QUERY, pick_word());
                else if (r < 8)
                    send_request($urandom_range(0, 1) ? FN_SPARE_7 : FN_SPARE_6, pick_word());
                else if ($urandom_range(0, 99) < push_pct)
                    send_request($urandom_range(0, 1) ? FN_PUSH_BACK : FN_PUSH_FRONT,
                                 pick_word());
                else
                    send_request($urandom_range(0, 1) ? FN_POP_BACK : FN_POP_FRONT,
                                 pick_word());
            end
        end
        idle_on = 1'b1;
    endtask

    // Back-to-back requests with the consumer always ready
    task automatic test_steady_stream();
        idle_on = 1'b0;
        repeat (40)
            send_request(3'($urandom_range(0, 3)), pick_word());
        idle_on = 1'b1;
    endtask

    initial begin
        reset_shadow();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_queue();
        test_both_ends();
        test_full_queue();
        test_random_mix();
        test_steady_stream();

        req_valid <= 1'b0;
        while (exp_wr != exp_rd) @(posedge clk);
        repeat (16) @(posedge clk);

        for (int k = exp_rd; k < exp_wr; k++)
            note_mismatch("missing result, occupancy",
                          32'(exp_store[k % EXP_SLOTS].occupancy), '0);

        $display("Covered %0d requests and %0d results; peak occupancy %0d.",
                 n_requests, n_results, peak_count);
        $display("Full-queue pushes: %0d, empty-queue pops: %0d, mismatches: %0d.",
                 n_full_hits, n_empty_hits, n_errors);
        if (n_errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
